// ===== design/stq_pkg.sv =====
package stq_pkg;

  localparam int unsigned POOL_DEPTH  = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned IDX_W       = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(POOL_DEPTH + 1);
  localparam int unsigned EV_IDX_W    = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int unsigned EV_CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int unsigned IN_DATA_W   = 128;
  localparam int unsigned OUT_DATA_W  = 104;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_CANCEL = 3'd1,
    OP_NOTIFY = 3'd2,
    OP_FIND   = 3'd3,
    OP_CHECK  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] deadline;
    logic [31:0] word;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        event_valid;
    logic        fired;
    logic [31:0] event_id;
    logic [31:0] event_data;
    logic        rearm;
    logic [31:0] rearm_delay;
    logic        queue_empty;
    logic        last;
  } result_t;

  function automatic logic [31:0] clip_delay(logic [31:0] dl, logic [31:0] now);
    logic [31:0] d;
    d = dl - now;
    return d[31] ? 32'd0 : d;
  endfunction

endpackage

// ===== design/stq_store.sv =====
module stq_store import stq_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [POOL_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/stq_obuf.sv =====
module stq_obuf import stq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  result_t               res_i,
  output logic                  free_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  logic    valid_q;
  result_t res_q;

  assign free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {2'b00, res_q.queue_empty, res_q.rearm_delay, res_q.rearm,
                          res_q.event_data, res_q.event_id, res_q.fired,
                          res_q.event_valid, res_q.status};

endmodule

// ===== design/sorted_timer_queue_top.sv =====
// path, accept to result: a scan reading one entry per cycle through the single memory
// read port, a decide step and the result push; a head re-read adds a read and a wait state,
// and a start that inserts adds a shift pass and a write before the push
// throughput: one item per pass, taken again the cycle after its last result is pushed;
// a check pushes one result per cycle, each waiting while the output register is full
// reset: asynchronous active low, empties the pool; no clearing pass is needed
module sorted_timer_queue_top import stq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // id, length, user_data, now
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [2:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status, event_valid, fired, event_id, event_data, rearm, rearm_delay, queue_empty
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_INSERT, S_HEAD_RD, S_HEAD_WAIT, S_EMIT
  } state_e;

  state_e               state_q;
  logic [2:0]           op_q;
  logic [31:0]          id_q, len_q, word_q, now_q, newdl_q;
  logic [CNT_W-1:0]     cnt_q, rd_ptr_q, w_q, pos_q, sh_ptr_q;
  logic                 rvalid_q, pos_found_q, match_q, head_hit_q;
  logic [IDX_W-1:0]     ridx_q;
  logic [31:0]          hit_word_q;
  logic [EV_CNT_W-1:0]  n_q, k_q, nres_q;
  logic                 ck_mode_q;
  logic [1:0]           r_status_q;
  logic                 r_ev_q, r_rearm_q, r_empty_q;
  logic [31:0]          r_id_q, r_data_q, r_delay_q;
  logic [63:0]          evbuf [MAX_RESULTS];

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  entry_t               mem_wdata, rdata;
  logic [31:0]          da, db;
  logic                 fut, idm, expd, rm;
  logic                 ob_free, push;
  result_t              res;
  logic                 last_res;

  stq_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  assign da   = rdata.deadline - now_q;
  assign db   = rdata.deadline - newdl_q;
  assign fut  = (da != 32'd0) && !da[31] && (db != 32'd0) && !db[31];
  assign idm  = rdata.id == id_q;
  assign expd = (da == 32'd0) || da[31];
  assign rm   = ((op_q == OP_CANCEL || op_q == OP_NOTIFY) && idm) ||
                (op_q == OP_CHECK && expd && (n_q < EV_CNT_W'(MAX_RESULTS)));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = w_q[IDX_W-1:0];
    mem_wdata = rdata;
    mem_raddr = rd_ptr_q[IDX_W-1:0];
    case (state_q)
      S_SCAN: begin
        mem_we = rvalid_q && !rm;
      end
      S_SHIFT: begin
        mem_raddr = IDX_W'(sh_ptr_q - CNT_W'(1));
        mem_we    = rvalid_q;
        mem_waddr = ridx_q + IDX_W'(1);
      end
      S_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[IDX_W-1:0];
        mem_wdata = '{id: id_q, deadline: newdl_q, word: word_q};
      end
      S_HEAD_RD: mem_raddr = '0;
      default: ;
    endcase
  end

  assign last_res = k_q == nres_q - EV_CNT_W'(1);

  always_comb begin
    res.status      = r_status_q;
    res.event_valid = r_ev_q;
    res.fired       = 1'b0;
    res.event_id    = r_id_q;
    res.event_data  = r_data_q;
    res.rearm       = r_rearm_q;
    res.rearm_delay = r_delay_q;
    res.queue_empty = r_empty_q;
    res.last        = last_res;
    if (ck_mode_q) begin
      res.event_valid = 1'b1;
      res.fired       = 1'b1;
      res.event_id    = evbuf[k_q[EV_IDX_W-1:0]][63:32];
      res.event_data  = evbuf[k_q[EV_IDX_W-1:0]][31:0];
      res.rearm       = last_res && r_rearm_q;
      res.rearm_delay = last_res ? r_delay_q : 32'd0;
    end
  end

  assign push          = (state_q == S_EMIT);
  assign s_axis_tready = (state_q == S_IDLE);

  stq_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .res_i         (res),
    .free_o        (ob_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && rvalid_q && rm && op_q == OP_CHECK) begin
      evbuf[n_q[EV_IDX_W-1:0]] <= {rdata.id, rdata.word};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      op_q        <= '0;
      id_q        <= '0;
      len_q       <= '0;
      word_q      <= '0;
      now_q       <= '0;
      newdl_q     <= '0;
      rd_ptr_q    <= '0;
      w_q         <= '0;
      pos_q       <= '0;
      sh_ptr_q    <= '0;
      rvalid_q    <= 1'b0;
      ridx_q      <= '0;
      pos_found_q <= 1'b0;
      match_q     <= 1'b0;
      head_hit_q  <= 1'b0;
      hit_word_q  <= '0;
      n_q         <= '0;
      k_q         <= '0;
      nres_q      <= '0;
      ck_mode_q   <= 1'b0;
      r_status_q  <= ST_OK;
      r_ev_q      <= 1'b0;
      r_rearm_q   <= 1'b0;
      r_empty_q   <= 1'b0;
      r_id_q      <= '0;
      r_data_q    <= '0;
      r_delay_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q        <= s_axis_tuser;
            id_q        <= s_axis_tdata[31:0];
            len_q       <= s_axis_tdata[63:32];
            word_q      <= s_axis_tdata[95:64];
            now_q       <= s_axis_tdata[127:96];
            newdl_q     <= s_axis_tdata[127:96] + s_axis_tdata[63:32];
            rd_ptr_q    <= '0;
            w_q         <= '0;
            n_q         <= '0;
            k_q         <= '0;
            rvalid_q    <= 1'b0;
            pos_found_q <= 1'b0;
            match_q     <= 1'b0;
            head_hit_q  <= 1'b0;
            state_q     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_ptr_q < cnt_q) rd_ptr_q <= rd_ptr_q + CNT_W'(1);
          rvalid_q <= rd_ptr_q < cnt_q;
          ridx_q   <= rd_ptr_q[IDX_W-1:0];
          if (rvalid_q) begin
            if (op_q == OP_START && fut && !pos_found_q) begin
              pos_q       <= CNT_W'(ridx_q);
              pos_found_q <= 1'b1;
            end
            if (idm) begin
              match_q    <= 1'b1;
              hit_word_q <= rdata.word;
            end
            if (rm) begin
              if (ridx_q == '0) head_hit_q <= 1'b1;
              if (op_q == OP_CHECK) n_q <= n_q + EV_CNT_W'(1);
            end else begin
              w_q <= w_q + CNT_W'(1);
            end
          end
          if (rd_ptr_q == cnt_q && !rvalid_q) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          cnt_q      <= w_q;
          r_status_q <= ST_OK;
          r_ev_q     <= 1'b0;
          r_id_q     <= '0;
          r_data_q   <= '0;
          r_rearm_q  <= 1'b0;
          r_delay_q  <= '0;
          r_empty_q  <= w_q == '0;
          nres_q     <= EV_CNT_W'(1);
          ck_mode_q  <= 1'b0;
          state_q    <= S_EMIT;
          case (op_q)
            OP_START: begin
              if (len_q == 32'd0 || match_q) begin
                r_status_q <= ST_REFUSED;
              end else if (cnt_q == CNT_W'(POOL_DEPTH)) begin
                r_status_q <= ST_FULL;
              end else begin
                if (!pos_found_q) pos_q <= cnt_q;
                sh_ptr_q <= cnt_q;
                rvalid_q <= 1'b0;
                state_q  <= S_SHIFT;
              end
            end
            OP_CANCEL, OP_NOTIFY: begin
              if (!match_q) begin
                r_status_q <= ST_NOTFOUND;
              end else begin
                if (op_q == OP_NOTIFY) begin
                  r_ev_q   <= 1'b1;
                  r_id_q   <= id_q;
                  r_data_q <= hit_word_q;
                end
                if (head_hit_q) state_q <= S_HEAD_RD;
              end
            end
            OP_FIND: begin
              if (match_q) begin
                r_id_q    <= id_q;
                r_data_q  <= hit_word_q;
                r_empty_q <= 1'b0;
              end else begin
                r_status_q <= ST_NOTFOUND;
              end
            end
            OP_CHECK: begin
              if (n_q != '0) begin
                ck_mode_q <= 1'b1;
                nres_q    <= n_q;
                state_q   <= S_HEAD_RD;
              end
            end
            OP_CLEAR: begin
              cnt_q     <= '0;
              r_empty_q <= 1'b1;
            end
            default: r_status_q <= ST_REFUSED;
          endcase
        end
        S_SHIFT: begin
          // move entries up one place, from the tail down to the insert point
          if (sh_ptr_q > pos_q) sh_ptr_q <= sh_ptr_q - CNT_W'(1);
          rvalid_q <= sh_ptr_q > pos_q;
          ridx_q   <= IDX_W'(sh_ptr_q - CNT_W'(1));
          if (sh_ptr_q == pos_q && !rvalid_q) state_q <= S_INSERT;
        end
        S_INSERT: begin
          cnt_q     <= cnt_q + CNT_W'(1);
          r_rearm_q <= pos_q == '0;
          r_delay_q <= (pos_q == '0) ? len_q : 32'd0;
          r_empty_q <= 1'b0;
          state_q   <= S_EMIT;
        end
        S_HEAD_RD: begin
          if (cnt_q == '0) begin
            r_rearm_q <= 1'b0;
            state_q   <= S_EMIT;
          end else begin
            state_q <= S_HEAD_WAIT;
          end
        end
        S_HEAD_WAIT: begin
          r_rearm_q <= 1'b1;
          r_delay_q <= clip_delay(rdata.deadline, now_q);
          state_q   <= S_EMIT;
        end
        S_EMIT: begin
          if (ob_free) begin
            k_q <= k_q + EV_CNT_W'(1);
            if (last_res) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // the pool never holds more timers than it has entries
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(POOL_DEPTH))
    else $error("timer count beyond pool depth");

  // an accepted item blocks the next one: ready is low in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while previous one in progress");

  // the rearm decision only rides on the final result of an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[68] |-> m_axis_tlast)
    else $error("rearm on a non-final result");

endmodule
